// ===== rtl/srs_pkg.sv =====
// srs_pkg: shared types and constants for the sorted range search block
// holds the input and result word structs, command codes and the control states
// no dependencies
package srs_pkg;

    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;
    localparam int DATA_W  = 32;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [SLOT_W-1:0]        slot_index;
        logic signed [DATA_W-1:0] data_value;
    } in_word_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] first_index;
        logic [SLOT_W-1:0] last_index;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOWER,
        ST_UPPER,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/srs_ram.sv =====
// srs_ram: generic single-port-write, single-port-read memory with registered read
// depends on nothing; the width and depth come from its parameters
module srs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/sorted_range_search.sv =====
// sorted_range_search: first and last occurrence of a key in a sorted store
// a write word gives no result; each search word gives one result word once its search is done
// one word at a time; a search holds the input while it runs, one probe per cycle,
// and longer while an earlier result word is stalled
// reset: control and the entry count clear; the store contents are not cleared
module sorted_range_search #(
    parameter int STORE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [srs_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  srs_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output srs_pkg::out_word_t            m_data
);
    import srs_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]           element_count_reg;
    logic [CW-1:0]                lo_reg, lo_next;
    logic [CW-1:0]                hi_reg, hi_next;
    logic [CW-1:0]                mid_reg, mid_next;
    logic [CW-1:0]                n_reg, n_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]                first_reg, first_next;
    logic                         eq_first_reg, eq_first_next;
    logic                         eq_last_reg, eq_last_next;
    logic                         res_found_reg, res_found_next;
    logic [CW-1:0]                res_last_reg, res_last_next;
    logic                         m_valid_reg, m_valid_next;
    out_word_t                    m_data_reg, m_data_next;

    // datapath signals
    logic                          accept;
    logic                          start_search;
    logic [CW-1:0]                 n_sat;
    logic signed [VALUE_WIDTH-1:0] in_value;
    logic signed [VALUE_WIDTH-1:0] probe_value;
    logic                          probe_eq;
    logic                          go_right;
    logic [CW-1:0]                 lo_p, hi_p, mid_p;
    logic                          probe_done;
    logic [CW-1:0]                 last_idx;
    logic                          eq_last_cur;
    logic                          found_now;
    logic                          emit_free;

    // memory port
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [VALUE_WIDTH-1:0] ram_rd_data;

    srs_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk    (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(in_value),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign accept       = s_valid && s_ready;
    assign start_search = accept && (s_data.cmd == CMD_SEARCH);
    assign emit_free    = !m_valid_reg || m_ready;

    // keys and entries are kept at VALUE_WIDTH bits, sign-extended or cut
    assign in_value = VALUE_WIDTH'(64'(s_data.data_value));

    assign n_sat = (32'(element_count_reg) > 32'(STORE_DEPTH)) ? CW'(STORE_DEPTH)
                                                               : CW'(element_count_reg);

    // one probe: compare the word read last cycle, narrow the range
    assign probe_value = $signed(ram_rd_data);
    assign probe_eq    = (probe_value == key_reg);
    assign go_right    = (state_reg == ST_UPPER) ? (probe_value <= key_reg)
                                                 : (probe_value < key_reg);
    assign lo_p        = go_right ? (mid_reg + CW'(1)) : lo_reg;
    assign hi_p        = go_right ? hi_reg : mid_reg;
    assign probe_done  = (lo_p >= hi_p);
    assign mid_p       = lo_p + ((hi_p - lo_p) >> 1);

    // last go-right probe of the upper search sits at past - 1
    assign last_idx    = lo_p - CW'(1);
    assign eq_last_cur = go_right ? probe_eq : eq_last_reg;
    assign found_now   = (first_reg < n_reg) && (lo_p != '0) && (last_idx >= first_reg)
                         && eq_first_reg && eq_last_cur;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_search) begin
                    state_next = (n_sat == '0) ? ST_EMIT : ST_LOWER;
                end
            end
            ST_LOWER: begin
                if (probe_done) begin
                    state_next = ST_UPPER;
                end
            end
            ST_UPPER: begin
                if (probe_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs; writes only land in idle, so no read is in flight then
    always_comb begin
        s_ready   = 1'b0;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ram_wr_en = s_valid && (s_data.cmd == CMD_WRITE)
                            && (32'(s_data.slot_index) < 32'(STORE_DEPTH));
                ram_rd_en = start_search;
            end
            ST_LOWER: begin
                ram_rd_en = 1'b1;
            end
            ST_UPPER: begin
                ram_rd_en = !probe_done;
            end
            ST_EMIT: begin
                ram_rd_en = 1'b0;
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    assign ram_wr_addr = AW'(s_data.slot_index);
    assign ram_rd_addr = mid_next[AW-1:0];

    // datapath
    always_comb begin
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        n_next         = n_reg;
        key_next       = key_reg;
        first_next     = first_reg;
        eq_first_next  = eq_first_reg;
        eq_last_next   = eq_last_reg;
        res_found_next = res_found_reg;
        res_last_next  = res_last_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (start_search) begin
                    key_next       = in_value;
                    n_next         = n_sat;
                    lo_next        = '0;
                    hi_next        = n_sat;
                    mid_next       = n_sat >> 1;
                    eq_first_next  = 1'b0;
                    eq_last_next   = 1'b0;
                    first_next     = '0;
                    res_found_next = 1'b0;
                    res_last_next  = '0;
                end
            end
            ST_LOWER: begin
                if (!go_right) begin
                    eq_first_next = probe_eq;
                end
                if (probe_done) begin
                    // lower bound found, restart over the full range
                    first_next = lo_p;
                    lo_next    = '0;
                    hi_next    = n_reg;
                    mid_next   = n_reg >> 1;
                end else begin
                    lo_next  = lo_p;
                    hi_next  = hi_p;
                    mid_next = mid_p;
                end
            end
            ST_UPPER: begin
                eq_last_next = eq_last_cur;
                lo_next      = lo_p;
                hi_next      = hi_p;
                if (probe_done) begin
                    res_found_next = found_now;
                    first_next     = found_now ? first_reg : '0;
                    res_last_next  = found_now ? last_idx : '0;
                end else begin
                    mid_next = mid_p;
                end
            end
            ST_EMIT: begin
                if (emit_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.found       = res_found_reg;
                    m_data_next.first_index = SLOT_W'(first_reg);
                    m_data_next.last_index  = SLOT_W'(res_last_reg);
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            m_valid_reg       <= 1'b0;
            element_count_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                element_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        n_reg         <= n_next;
        key_reg       <= key_next;
        first_reg     <= first_next;
        eq_first_reg  <= eq_first_next;
        eq_last_reg   <= eq_last_next;
        res_found_reg <= res_found_next;
        res_last_reg  <= res_last_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/srs_checker.sv =====
// srs_checker: port-level assertions for sorted_range_search, bound to the top level
// depends on srs_pkg for the word types
module srs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input srs_pkg::in_word_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input srs_pkg::out_word_t  m_data
);
    import srs_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a miss reports both indices as zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.first_index == '0 && m_data.last_index == '0)
        else $error("miss with nonzero index");

    // a hit never has its range reversed
    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.last_index >= m_data.first_index)
        else $error("hit with last index below first index");

    // a search closes the input side once it is taken
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd == CMD_SEARCH |=> !s_ready)
        else $error("new word taken right after a search started");

    // no result word right out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sorted_range_search srs_checker u_srs_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
